/* hdl/dmrt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dmrt_pkg;

  // command limits and trim range (trim is unsigned Q2.8)
  localparam int SPEED_LIMIT = 255;
  localparam int TRIM_SHIFT  = 8;

  localparam logic [9:0] TRIM_MIN         = 10'd128;
  localparam logic [9:0] TRIM_MAX         = 10'd512;
  localparam logic [9:0] LEFT_GAIN_RESET  = 10'd294;
  localparam logic [9:0] RIGHT_GAIN_RESET = 10'd256;

  // register index as decoded from paddr[2]
  localparam logic REG_LEFT_GAIN  = 1'b0;
  localparam logic REG_RIGHT_GAIN = 1'b1;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int APB_ADDR_W  = 3;

  typedef logic signed [8:0] cmd_t;
  typedef logic [9:0]        trim_t;

  // input payload, last field in the lowest bits
  typedef struct packed {
    logic [8:0]         slew_step;
    logic signed [15:0] right_target;
    logic signed [15:0] left_target;
  } in_data_t;

  typedef struct packed {
    logic     mode;
    in_data_t data;
  } item_t;

  typedef struct packed {
    cmd_t left;
    cmd_t right;
  } cmd_pair_t;

  typedef struct packed {
    trim_t left;
    trim_t right;
  } trim_pair_t;

  // one bridge side, fwd in the lowest bit
  typedef struct packed {
    logic [7:0] duty;
    logic       rev;
    logic       fwd;
  } side_t;

  // result payload, left side in the lowest bits
  typedef struct packed {
    cmd_t  right_command;
    cmd_t  left_command;
    side_t right;
    side_t left;
  } res_t;

  localparam logic signed [15:0] TGT_MAX = 16'(SPEED_LIMIT);
  localparam logic signed [15:0] TGT_MIN = -16'(SPEED_LIMIT);
  localparam logic [9:0]         DUTY_MAX = 10'(SPEED_LIMIT);

  // clamp a raw target to the command range
  function automatic cmd_t sat_target(input logic signed [15:0] t);
    cmd_t r;
    if (t > TGT_MAX) begin
      r = 9'(SPEED_LIMIT);
    end else if (t < TGT_MIN) begin
      r = -9'(SPEED_LIMIT);
    end else begin
      r = t[8:0];
    end
    return r;
  endfunction

  // clamp a written trim value to 0.5..2.0
  function automatic trim_t sat_trim(input logic [9:0] v);
    trim_t r;
    if (v < TRIM_MIN) begin
      r = TRIM_MIN;
    end else if (v > TRIM_MAX) begin
      r = TRIM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // move cur toward tgt by at most step, zero step counts as one
  function automatic cmd_t ramp_toward(input cmd_t cur, input cmd_t tgt,
                                       input logic [8:0] step);
    logic signed [10:0] cur_w;
    logic signed [10:0] tgt_w;
    logic signed [10:0] step_w;
    logic signed [10:0] up;
    logic signed [10:0] dn;
    cmd_t r;
    cur_w  = 11'(cur);
    tgt_w  = 11'(tgt);
    step_w = (step == 9'd0) ? 11'sd1 : $signed({2'b00, step});
    up     = cur_w + step_w;
    dn     = cur_w - step_w;
    if (cur_w < tgt_w) begin
      r = (up > tgt_w) ? tgt : up[8:0];
    end else if (cur_w > tgt_w) begin
      r = (dn < tgt_w) ? tgt : dn[8:0];
    end else begin
      r = cur;
    end
    return r;
  endfunction

  // scale one command by its trim, truncate toward zero, saturate
  function automatic side_t trim_side(input cmd_t cmd, input trim_t trim);
    logic       neg;
    logic [8:0] mag9;
    logic [17:0] prod;
    logic [9:0] q;
    side_t      s;
    neg  = cmd[8];
    mag9 = neg ? 9'(-cmd) : 9'(cmd);
    prod = 18'(mag9[7:0]) * 18'(trim);
    q    = prod[17:TRIM_SHIFT];
    s.duty = (q > DUTY_MAX) ? DUTY_MAX[7:0] : q[7:0];
    s.fwd  = !neg && (s.duty != 8'd0);
    s.rev  = neg && (s.duty != 8'd0);
    return s;
  endfunction

endpackage
`default_nettype wire

/* hdl/dmrt_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
module dmrt_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [dmrt_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready,
  output dmrt_pkg::trim_pair_t                    trims
);
  import dmrt_pkg::*;

  logic  wr_en;
  logic  reg_idx;
  trim_t left_gain;
  trim_t right_gain;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  // trim registers, saturated on write
  always_ff @(posedge clk) begin
    if (rst) begin
      left_gain  <= LEFT_GAIN_RESET;
      right_gain <= RIGHT_GAIN_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LEFT_GAIN:  left_gain  <= sat_trim(pwdata[9:0]);
        REG_RIGHT_GAIN: right_gain <= sat_trim(pwdata[9:0]);
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_LEFT_GAIN:  prdata = {22'd0, left_gain};
      REG_RIGHT_GAIN: prdata = {22'd0, right_gain};
      default:        prdata = 32'd0;
    endcase
  end

  assign trims.left  = left_gain;
  assign trims.right = right_gain;

endmodule
`default_nettype wire

/* hdl/dmrt_ramp.sv */
`timescale 1ns / 1ps
`default_nettype none
module dmrt_ramp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dmrt_pkg::item_t     in_item,
  output logic                     cmd_valid,
  input  wire logic                cmd_ready,
  output dmrt_pkg::cmd_pair_t      cmd
);
  import dmrt_pkg::*;

  logic      hold_valid;
  item_t     hold_item;
  logic      cmd_load;
  cmd_t      tgt_left;
  cmd_t      tgt_right;
  cmd_pair_t cmd_next;

  assign cmd_load = hold_valid && (!cmd_valid || cmd_ready);
  assign in_ready = !hold_valid || cmd_load;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_item <= in_item;
    end
  end

  // saturate targets, then set or ramp from the stored commands
  always_comb begin
    tgt_left  = sat_target(hold_item.data.left_target);
    tgt_right = sat_target(hold_item.data.right_target);
    if (hold_item.mode) begin
      cmd_next.left  = ramp_toward(cmd.left, tgt_left, hold_item.data.slew_step);
      cmd_next.right = ramp_toward(cmd.right, tgt_right, hold_item.data.slew_step);
    end else begin
      cmd_next.left  = tgt_left;
      cmd_next.right = tgt_right;
    end
  end

  // command register, also the last-command state
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd       <= '0;
    end else begin
      if (!cmd_valid || cmd_ready) begin
        cmd_valid <= hold_valid;
      end
      if (cmd_load) begin
        cmd <= cmd_next;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/dmrt_trim.sv */
`timescale 1ns / 1ps
`default_nettype none
module dmrt_trim (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  input  wire dmrt_pkg::cmd_pair_t   cmd,
  input  wire dmrt_pkg::trim_pair_t  trims,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output dmrt_pkg::res_t             res
);
  import dmrt_pkg::*;

  res_t res_next;

  assign cmd_ready = !res_valid || res_ready;

  // per-side trim multiply and bridge decode
  always_comb begin
    res_next.left          = trim_side(cmd.left, trims.left);
    res_next.right         = trim_side(cmd.right, trims.right);
    res_next.left_command  = cmd.left;
    res_next.right_command = cmd.right;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_ready) begin
      res_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/dual_motor_ramp_trim_drive.sv */
`timescale 1ns / 1ps
`default_nettype none
// Two-sided H-bridge drive with slew limiting and per-side gain trim. Each input
// transaction carries left/right speed targets and a ramp step in s_tdata and the
// mode in s_tuser (0 sets the command, 1 ramps from the last command by at most
// the step). One result transaction per input: bridge direction bits, PWM duty
// and the untrimmed commands. Throughput is one transaction per clock while
// m_tready is high; the path is the input register, the command register that
// also holds the ramp state and the result register after the trim multiplier.
// Trims are Q2.8 at byte addresses 0 (left) and 4 (right) and
// clamp to 0.5..2.0 on write; change them only while the pipeline is empty.
module dual_motor_ramp_trim_drive (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // [15:0] left_target, [31:16] right_target, [40:32] slew_step, rest zero
  input  wire logic [dmrt_pkg::IN_TDATA_W-1:0]     s_tdata,
  // [0] mode
  input  wire logic                                s_tuser,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // [0] left_fwd, [1] left_rev, [9:2] left_duty, [10] right_fwd, [11] right_rev,
  // [19:12] right_duty, [28:20] left_command, [37:29] right_command, rest zero
  output logic [dmrt_pkg::OUT_TDATA_W-1:0]         m_tdata,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [dmrt_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);
  import dmrt_pkg::*;

  item_t      in_item;
  trim_pair_t trims;
  logic       cmd_valid;
  logic       cmd_ready;
  cmd_pair_t  cmd;
  res_t       res;

  assign in_item.mode = s_tuser;
  assign in_item.data = s_tdata[$bits(in_data_t)-1:0];

  // configuration registers
  dmrt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .trims   (trims)
  );

  // target saturation and ramp
  dmrt_ramp u_ramp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // trim and bridge outputs
  dmrt_trim u_trim (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .trims     (trims),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {(OUT_TDATA_W - $bits(res_t))'(0), res};

  // a bridge side is never driven both ways
  a_no_shoot_through: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(res.left.fwd && res.left.rev) && !(res.right.fwd && res.right.rev))
    else $error("bridge side driven forward and reverse");

  // zero duty exactly when the side is off
  a_duty_matches_dir: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((res.left.duty == 8'd0) == !(res.left.fwd || res.left.rev)) &&
                 ((res.right.duty == 8'd0) == !(res.right.fwd || res.right.rev)))
    else $error("duty and direction bits disagree");

  // stored commands stay inside the speed limit
  a_cmd_range: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> (cmd.left != -9'sd256) && (cmd.right != -9'sd256))
    else $error("command outside speed limit");

  // trims stay inside 0.5..2.0
  a_trim_range: assert property (@(posedge clk) disable iff (rst)
    (trims.left >= TRIM_MIN) && (trims.left <= TRIM_MAX) &&
    (trims.right >= TRIM_MIN) && (trims.right <= TRIM_MAX))
    else $error("trim register out of range");

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import dmrt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // [15:0] left_target, [31:16] right_target, [40:32] slew_step, rest zero
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  // [0] mode
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [0] left_fwd, [1] left_rev, [9:2] left_duty, [10] right_fwd, [11] right_rev,
  // [19:12] right_duty, [28:20] left_command, [37:29] right_command, rest zero
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // model of the drive: gains and last stored commands
  trim_t left_gain  = LEFT_GAIN_RESET;
  trim_t right_gain = RIGHT_GAIN_RESET;
  int    left_cmd_state  = 0;
  int    right_cmd_state = 0;

  res_t  pending_drives[$];
  int    mismatch_count = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;

  dual_motor_ramp_trim_drive DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic int clamp_speed(input int v);
    if (v > SPEED_LIMIT) return SPEED_LIMIT;
    if (v < -SPEED_LIMIT) return -SPEED_LIMIT;
    return v;
  endfunction

  function automatic trim_t clamp_gain(input logic [31:0] v);
    int w;
    w = int'(v[9:0]);
    if (w < 128) w = 128;
    if (w > 512) w = 512;
    return trim_t'(w);
  endfunction

  // slew one side toward its target without passing it
  function automatic int slew_command(input int cur, input int tgt, input int step);
    int r;
    r = cur;
    if (cur < tgt) begin
      r = cur + step;
      if (r > tgt) r = tgt;
    end else if (cur > tgt) begin
      r = cur - step;
      if (r < tgt) r = tgt;
    end
    return clamp_speed(r);
  endfunction

  // gain-scaled bridge outputs for one side
  function automatic side_t bridge_side(input int cmd, input trim_t gain);
    int    mag;
    int    q;
    side_t s;
    mag = (cmd < 0) ? -cmd : cmd;
    q = (mag * int'(gain)) / 256;
    if (q > SPEED_LIMIT) q = SPEED_LIMIT;
    s.duty = 8'(q);
    s.fwd  = (cmd > 0) && (q != 0);
    s.rev  = (cmd < 0) && (q != 0);
    return s;
  endfunction

  // next commands and bridge result for one accepted transaction
  function automatic res_t predict_drive(input logic mode, input logic signed [15:0] lt,
                                         input logic signed [15:0] rt,
                                         input logic [8:0] step);
    int   tl;
    int   tr;
    int   st;
    res_t r;
    tl = clamp_speed(int'(lt));
    tr = clamp_speed(int'(rt));
    st = (step == 9'd0) ? 1 : int'(step);
    if (mode) begin
      left_cmd_state  = slew_command(left_cmd_state, tl, st);
      right_cmd_state = slew_command(right_cmd_state, tr, st);
    end else begin
      left_cmd_state  = tl;
      right_cmd_state = tr;
    end
    r.left          = bridge_side(left_cmd_state, left_gain);
    r.right         = bridge_side(right_cmd_state, right_gain);
    r.left_command  = cmd_t'(left_cmd_state);
    r.right_command = cmd_t'(right_cmd_state);
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(res_t)-1:0];
      if (pending_drives.size() == 0) begin
        $error("result transaction with no prediction pending: %h", m_tdata);
        mismatch_count++;
      end else begin
        want = pending_drives.pop_front();
        check_field("left_fwd", want.left.fwd, got.left.fwd);
        check_field("left_rev", want.left.rev, got.left.rev);
        check_field("left_duty", want.left.duty, got.left.duty);
        check_field("right_fwd", want.right.fwd, got.right.fwd);
        check_field("right_rev", want.right.rev, got.right.rev);
        check_field("right_duty", want.right.duty, got.right.duty);
        check_field("left_command", $signed(want.left_command), $signed(got.left_command));
        check_field("right_command", $signed(want.right_command),
                    $signed(got.right_command));
      end
    end
  end

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(input logic mode, input logic signed [15:0] lt,
                           input logic signed [15:0] rt, input logic [8:0] step);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {7'b0, step, rt, lt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_drives.push_back(predict_drive(mode, lt, rt, step));
  endtask

  // stop sending and let the pipeline empty
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_trim(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_LEFT_GAIN) left_gain = clamp_gain(value);
    else right_gain = clamp_gain(value);
    @(posedge clk);
  endtask

  task automatic read_trim(input logic reg_sel);
    logic [31:0] want;
    want = {22'b0, (reg_sel == REG_LEFT_GAIN) ? left_gain : right_gain};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_sel, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("%s readback mismatch: expected %0d, actual %0d",
             (reg_sel == REG_LEFT_GAIN) ? "left gain" : "right gain", want, prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_trims();
    read_trim(REG_LEFT_GAIN);
    read_trim(REG_RIGHT_GAIN);
  endtask

  // saturation, both modes, zero step, overshoot clamp, zero drive
  task automatic test_directed_items();
    send_item(1'b0, 16'sh7FFF, 16'sh8000, 9'd0);
    send_item(1'b0, 16'sd256, -16'sd256, 9'd3);
    send_item(1'b0, 16'sd255, -16'sd255, 9'd511);
    send_item(1'b0, 16'sd0, 16'sd0, 9'd0);
    send_item(1'b1, 16'sd255, -16'sd255, 9'd0);
    send_item(1'b1, 16'sd255, -16'sd255, 9'd511);
    send_item(1'b1, 16'sh8000, 16'sh7FFF, 9'd100);
    send_item(1'b1, -16'sd255, 16'sd255, 9'd511);
    send_item(1'b1, -16'sd255, 16'sd255, 9'd7);
    send_item(1'b0, 16'sd1, -16'sd1, 9'd5);
    send_item(1'b1, 16'sd0, 16'sd0, 9'd3);
    send_item(1'b0, 16'sd100, -16'sd100, 9'd0);
    send_item(1'b1, 16'sd120, -16'sd80, 9'd50);
    send_item(1'b1, -16'sd16, 16'sd300, 9'd0);
    send_item(1'b0, 16'sh8001, 16'sh7FFE, 9'd256);
    send_item(1'b1, 16'sh5555, 16'shAAAA, 9'd170);
    send_item(1'b0, -16'sd1, 16'sd1, 9'd1);
    send_item(1'b1, -16'sd1, 16'sd1, 9'd0);
    drain_pipeline();
  endtask

  // trim writes across and beyond the legal range, with readback
  task automatic test_trim_writes();
    logic [31:0] values[10];
    values = '{32'd0, 32'd127, 32'd128, 32'd129, 32'd511, 32'd512, 32'd513, 32'd1023,
               32'hFFFF_FD2C, 32'h0000_0400};
    foreach (values[i]) begin
      write_trim(REG_LEFT_GAIN, values[i]);
      write_trim(REG_RIGHT_GAIN, values[9 - i]);
      read_trim(REG_LEFT_GAIN);
      read_trim(REG_RIGHT_GAIN);
    end
    write_trim(REG_LEFT_GAIN, 32'd512);
    write_trim(REG_RIGHT_GAIN, 32'd128);
  endtask

  function automatic logic signed [15:0] random_target();
    case ($urandom_range(9))
      6, 7:    return 16'($urandom);
      8:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      9:       return 16'((int'($urandom_range(3)) + 253) * ($urandom_range(1) ? 1 : -1));
      default: return 16'(int'($urandom_range(600)) - 300);
    endcase
  endfunction

  // mostly ramp sequences, with direct sets and wide steps mixed in
  task automatic test_random_items(input int count);
    logic [8:0] step;
    repeat (count) begin
      step = ($urandom_range(3) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(24));
      send_item($urandom_range(9) < 7, random_target(), random_target(), step);
    end
    drain_pipeline();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 29;
    recv_idle_pct = 52;
    test_reset_trims();
    test_directed_items();
    test_trim_writes();
    test_random_items(200);
    write_trim(REG_LEFT_GAIN, 32'd0);
    write_trim(REG_RIGHT_GAIN, 32'd600);
    send_idle_pct = 52;
    recv_idle_pct = 29;
    test_random_items(200);
    write_trim(REG_LEFT_GAIN, $urandom);
    write_trim(REG_RIGHT_GAIN, $urandom);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_items(200);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
